// ----- rtl/core/bounded_undo_redo_history_defines.svh -----
// Assertion helpers shared by the checker of the undo and redo history.
`ifndef BOUNDED_UNDO_REDO_HISTORY_DEFINES_SVH
`define BOUNDED_UNDO_REDO_HISTORY_DEFINES_SVH

// Implication in the same cycle, sampled on the checker clock.
`define BURH_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Implication in the next cycle, sampled on the checker clock.
`define BURH_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/burh_pkg.sv -----
`timescale 1ns / 1ps
package burh_pkg;

    localparam int CNT_W  = 7;
    localparam int WORD_W = 64;

    typedef enum logic [1:0] {
        MODE_PUSH  = 2'd0,
        MODE_UNDO  = 2'd1,
        MODE_REDO  = 2'd2,
        MODE_CLEAR = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NO_UNDO = 2'd1,
        ST_NO_REDO = 2'd2
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_OUT  = 1'b1
    } t_state;

    typedef struct packed {
        logic accept;
        logic cfg_write;
    } t_ctrl_cmd;

    typedef struct packed {
        logic empty;
    } t_dp_status;

endpackage

// ----- rtl/core/burh_cmd_if.sv -----
`timescale 1ns / 1ps
interface burh_cmd_if import burh_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [1:0]          mode;
    logic [WORD_W-1:0]   entry_in;

    modport source (output valid, output mode, output entry_in, input ready);
    modport sink   (input valid, input mode, input entry_in, output ready);
endinterface

// ----- rtl/core/burh_rsp_if.sv -----
`timescale 1ns / 1ps
interface burh_rsp_if import burh_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [WORD_W-1:0]   entry_out;
    logic [1:0]          status;
    logic [CNT_W-1:0]    undo_count;
    logic [CNT_W-1:0]    redo_count;

    modport source (output valid, output entry_out, output status,
                    output undo_count, output redo_count, input ready);
    modport sink   (input valid, input entry_out, input status,
                    input undo_count, input redo_count, output ready);
endinterface

// ----- rtl/core/burh_cfg_if.sv -----
`timescale 1ns / 1ps
interface burh_cfg_if import burh_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [CNT_W-1:0]   data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/core/burh_ctrl.sv -----
`timescale 1ns / 1ps
module burh_ctrl import burh_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_out_ready,
    input  logic       i_cfg_valid,
    input  t_dp_status i_status,
    output logic       o_in_ready,
    output logic       o_out_valid,
    output logic       o_cfg_ready,
    output t_ctrl_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign accept = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_out_ready && !accept) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
            end
            S_OUT: begin
                o_out_valid = 1'b1;
                o_in_ready  = i_out_ready;
            end
            default: begin
                o_in_ready  = 1'b0;
                o_out_valid = 1'b0;
            end
        endcase
    end

    assign o_cfg_ready     = 1'b1;
    assign o_cmd.accept    = accept;
    assign o_cmd.cfg_write = i_cfg_valid && i_status.empty;

endmodule

// ----- rtl/core/burh_datapath.sv -----
`timescale 1ns / 1ps
module burh_datapath import burh_pkg::*; #(
    parameter int DEPTH      = 64,
    parameter int ENTRY_BITS = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_ctrl_cmd         i_cmd,
    input  logic [1:0]        i_mode,
    input  logic [WORD_W-1:0] i_entry_in,
    input  logic [CNT_W-1:0]  i_cfg_data,
    output t_dp_status        o_status,
    output logic [WORD_W-1:0] o_entry_out,
    output logic [1:0]        o_result_status,
    output logic [CNT_W-1:0]  o_undo_count,
    output logic [CNT_W-1:0]  o_redo_count
);

    localparam int IDX_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SUM_W     = ((IDX_W > CNT_W) ? IDX_W : CNT_W) + 1;
    localparam int RESET_MAX = (DEPTH < 64) ? DEPTH : 64;

    logic [ENTRY_BITS-1:0] mem [DEPTH];

    logic [IDX_W-1:0]      r_oldest;
    logic [CNT_W-1:0]      r_cursor;
    logic [CNT_W-1:0]      r_count;
    logic [CNT_W-1:0]      r_max;
    logic [ENTRY_BITS-1:0] r_rd_data;
    logic                  r_use_rd;
    t_status               r_status;
    logic [CNT_W-1:0]      r_undo;
    logic [CNT_W-1:0]      r_redo;

    logic [IDX_W-1:0]      n_oldest;
    logic [CNT_W-1:0]      n_cursor;
    logic [CNT_W-1:0]      n_count;
    logic [CNT_W-1:0]      n_max;
    t_status               n_status;
    logic                  n_use_rd;

    logic [CNT_W-1:0]      mem_off;
    logic [IDX_W-1:0]      mem_addr;
    logic [IDX_W-1:0]      next_oldest;
    logic                  mem_wr;
    logic                  mem_rd;

    function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] base,
                                                 input logic [CNT_W-1:0] off);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(base) + SUM_W'(off);
        if (sum >= SUM_W'(DEPTH)) begin
            sum = sum - SUM_W'(DEPTH);
        end
        return sum[IDX_W-1:0];
    endfunction

    always_comb begin
        n_oldest = r_oldest;
        n_cursor = r_cursor;
        n_count  = r_count;
        n_status = ST_OK;
        n_use_rd = 1'b0;
        mem_off  = r_cursor;
        mem_wr   = 1'b0;
        mem_rd   = 1'b0;
        case (t_mode'(i_mode))
            MODE_PUSH: begin
                mem_wr = i_cmd.accept;
                if (r_cursor >= r_max) begin
                    n_oldest = next_oldest;
                    n_count  = r_cursor;
                end else begin
                    n_cursor = r_cursor + CNT_W'(1);
                    n_count  = r_cursor + CNT_W'(1);
                end
            end
            MODE_UNDO: begin
                mem_off = r_cursor - CNT_W'(1);
                if (r_cursor == '0) begin
                    n_status = ST_NO_UNDO;
                end else begin
                    n_cursor = r_cursor - CNT_W'(1);
                    n_use_rd = 1'b1;
                    mem_rd   = i_cmd.accept;
                end
            end
            MODE_REDO: begin
                if (r_cursor >= r_count) begin
                    n_status = ST_NO_REDO;
                end else begin
                    n_cursor = r_cursor + CNT_W'(1);
                    n_use_rd = 1'b1;
                    mem_rd   = i_cmd.accept;
                end
            end
            MODE_CLEAR: begin
                n_oldest = '0;
                n_cursor = '0;
                n_count  = '0;
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
    end

    assign mem_addr    = slot_of(r_oldest, mem_off);
    assign next_oldest = slot_of(r_oldest, CNT_W'(1));

    always_comb begin
        if (i_cfg_data == '0) begin
            n_max = CNT_W'(1);
        end else if (int'(i_cfg_data) > DEPTH) begin
            n_max = CNT_W'(DEPTH);
        end else begin
            n_max = i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_wr) begin
            mem[mem_addr] <= i_entry_in[ENTRY_BITS-1:0];
        end
        if (mem_rd) begin
            r_rd_data <= mem[mem_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oldest <= '0;
            r_cursor <= '0;
            r_count  <= '0;
            r_max    <= CNT_W'(RESET_MAX);
        end else begin
            if (i_cmd.accept) begin
                r_oldest <= n_oldest;
                r_cursor <= n_cursor;
                r_count  <= n_count;
            end
            if (i_cmd.cfg_write) begin
                r_max <= n_max;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_use_rd <= n_use_rd;
            r_status <= n_status;
            r_undo   <= n_cursor;
            r_redo   <= n_count - n_cursor;
        end
    end

    assign o_status.empty  = (r_count == '0);
    assign o_entry_out     = r_use_rd ? WORD_W'(r_rd_data) : '0;
    assign o_result_status = r_status;
    assign o_undo_count    = r_undo;
    assign o_redo_count    = r_redo;

endmodule

// ----- rtl/core/bounded_undo_redo_history.sv -----
// A result is valid in the cycle after its command transaction.
// Throughput: one command per cycle while results are taken each cycle; the
// single result register holds off the next command while its result waits.
// Reset clears the pointers, the entry count and the handshake state and sets
// the capacity to the smaller of DEPTH and 64; the store is not cleared.
`timescale 1ns / 1ps
module bounded_undo_redo_history import burh_pkg::*; #(
    parameter int DEPTH      = 64,
    parameter int ENTRY_BITS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    burh_cmd_if.sink    i_cmd,
    burh_rsp_if.source  o_rsp,
    burh_cfg_if.sink    i_cfg
);

    t_ctrl_cmd  cmd;
    t_dp_status dp_status;

    burh_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_cmd.valid),
        .i_out_ready (o_rsp.ready),
        .i_cfg_valid (i_cfg.valid),
        .i_status    (dp_status),
        .o_in_ready  (i_cmd.ready),
        .o_out_valid (o_rsp.valid),
        .o_cfg_ready (i_cfg.ready),
        .o_cmd       (cmd)
    );

    burh_datapath #(
        .DEPTH      (DEPTH),
        .ENTRY_BITS (ENTRY_BITS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_mode          (i_cmd.mode),
        .i_entry_in      (i_cmd.entry_in),
        .i_cfg_data      (i_cfg.data),
        .o_status        (dp_status),
        .o_entry_out     (o_rsp.entry_out),
        .o_result_status (o_rsp.status),
        .o_undo_count    (o_rsp.undo_count),
        .o_redo_count    (o_rsp.redo_count)
    );

endmodule

// ----- rtl/core/burh_checker.sv -----
`timescale 1ns / 1ps
`include "bounded_undo_redo_history_defines.svh"
module burh_checker import burh_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              i_in_ready,
    input logic [1:0]        i_mode,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input logic [WORD_W-1:0] i_entry_out,
    input logic [1:0]        i_status,
    input logic [CNT_W-1:0]  i_undo_count,
    input logic [CNT_W-1:0]  i_redo_count
);

    `BURH_ASSERT_SAME(a_no_undo, i_out_valid && i_status == ST_NO_UNDO, i_undo_count == '0 && i_entry_out == '0, "undo failure with entries to undo")
    `BURH_ASSERT_SAME(a_no_redo, i_out_valid && i_status == ST_NO_REDO, i_redo_count == '0 && i_entry_out == '0, "redo failure with entries to redo")
    `BURH_ASSERT_NEXT(a_clear, i_in_valid && i_in_ready && i_mode == MODE_CLEAR, i_out_valid && i_undo_count == '0 && i_redo_count == '0, "clear left entries")
    `BURH_ASSERT_NEXT(a_result, i_in_valid && i_in_ready, i_out_valid, "command produced no result")
    `BURH_ASSERT_NEXT(a_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(i_entry_out) && $stable(i_status) && $stable(i_undo_count) && $stable(i_redo_count), "stalled result changed")

endmodule

bind bounded_undo_redo_history burh_checker u_burh_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_cmd.valid),
    .i_in_ready   (i_cmd.ready),
    .i_mode       (i_cmd.mode),
    .i_out_valid  (o_rsp.valid),
    .i_out_ready  (o_rsp.ready),
    .i_entry_out  (o_rsp.entry_out),
    .i_status     (o_rsp.status),
    .i_undo_count (o_rsp.undo_count),
    .i_redo_count (o_rsp.redo_count)
);
